// File: rtl/rgbhsv_pkg.sv
// Shared widths, constants and types for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    localparam int CH_W        = 8;
    localparam int HUE_W       = 9;
    localparam int SAT_W       = 7;
    localparam int SUM_W       = 10;
    localparam int REM_W       = 15;
    localparam int Q_W         = 7;
    localparam int DIV_STAGES  = Q_W;
    localparam int LATENCY     = DIV_STAGES + 3;

    localparam int HUE_MUL     = 60;
    localparam int SAT_MUL     = 100;
    localparam int THIRD_MUL   = 43691;
    localparam int THIRD_SHIFT = 17;
    localparam int GRAY_PROD_W = SUM_W + THIRD_SHIFT;

    localparam int HUE_FULL    = 360;
    localparam int HUE_GREEN   = 120;
    localparam int HUE_BLUE    = 240;
    localparam int SAT_FULL    = 100;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    typedef struct packed {
        sector_t            sector;
        logic               neg;
        logic               flat;
        logic [CH_W-1:0]    val;
        logic [CH_W-1:0]    gray;
        logic [CH_W-1:0]    dh;
        logic [REM_W-1:0]   rem_h;
        logic [Q_W-1:0]     q_h;
        logic [REM_W-1:0]   rem_s;
        logic [Q_W-1:0]     q_s;
    } div_stage_t;

endpackage

// File: rtl/rgb_to_hsv_pixel.sv
// Pipelined RGB to HSV pixel converter with channel maximum and grey level.
// A request taken with start gives its result with done high after two front stages,
// seven divider stages and one output stage.
// Throughput: one request per clock; busy is always low and the receiver cannot stall.
// The two quotients come from restoring dividers that resolve one quotient bit per stage.
// Reset clears the valid bits of the pipeline and done; data registers are not reset.
module rgb_to_hsv_pixel
    import rgbhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CH_W-1:0]   red_in,
    input  logic [CH_W-1:0]   green_in,
    input  logic [CH_W-1:0]   blue_in,
    output logic              done,
    output logic [HUE_W-1:0]  hue_deg,
    output logic [SAT_W-1:0]  sat_pct,
    output logic [CH_W-1:0]   val_max,
    output logic [CH_W-1:0]   gray_avg
);

    logic                   s1_valid_reg;
    sector_t                s1_sector_reg, s1_sector_next;
    logic                   s1_neg_reg, s1_neg_next;
    logic [CH_W-1:0]        s1_mag_reg, s1_mag_next;
    logic [CH_W-1:0]        s1_d_reg, s1_d_next;
    logic [CH_W-1:0]        s1_max_reg, s1_max_next;
    logic [SUM_W-1:0]       s1_sum_reg, s1_sum_next;

    logic [DIV_STAGES:0]    v_reg;
    div_stage_t             st_reg  [0:DIV_STAGES];
    div_stage_t             st_next [0:DIV_STAGES];

    logic                   done_reg;
    logic [HUE_W-1:0]       hue_reg, hue_next;
    logic [SAT_W-1:0]       sat_reg, sat_next;
    logic [CH_W-1:0]        val_reg;
    logic [CH_W-1:0]        gray_reg;

    logic [GRAY_PROD_W-1:0] third_prod;

    assign busy = 1'b0;

    // Front stage: sector and value of the maximum, spread, signed hue difference, sum.
    always_comb
    begin
        logic [CH_W-1:0] mn;
        logic [CH_W-1:0] a;
        logic [CH_W-1:0] b;
        if (red_in >= green_in && red_in >= blue_in)
        begin
            s1_sector_next = SECT_RED;
            s1_max_next    = red_in;
            a              = green_in;
            b              = blue_in;
        end
        else if (green_in >= blue_in)
        begin
            s1_sector_next = SECT_GREEN;
            s1_max_next    = green_in;
            a              = blue_in;
            b              = red_in;
        end
        else
        begin
            s1_sector_next = SECT_BLUE;
            s1_max_next    = blue_in;
            a              = red_in;
            b              = green_in;
        end
        mn = red_in;
        if (green_in < mn)
        begin
            mn = green_in;
        end
        if (blue_in < mn)
        begin
            mn = blue_in;
        end
        s1_d_next   = s1_max_next - mn;
        s1_neg_next = (a < b);
        s1_mag_next = s1_neg_next ? (b - a) : (a - b);
        s1_sum_next = SUM_W'(red_in) + SUM_W'(green_in) + SUM_W'(blue_in);
    end

    assign third_prod = GRAY_PROD_W'(s1_sum_reg) * GRAY_PROD_W'(THIRD_MUL);

    // Second stage: scaled numerators, grey, flat flag; one quotient bit per divider stage.
    always_comb
    begin
        logic [REM_W-1:0] sh_h;
        logic [REM_W-1:0] sh_s;
        st_next[0].sector = s1_sector_reg;
        st_next[0].neg    = s1_neg_reg;
        st_next[0].flat   = (s1_d_reg == '0);
        st_next[0].val    = s1_max_reg;
        st_next[0].gray   = third_prod[THIRD_SHIFT +: CH_W];
        st_next[0].dh     = s1_d_reg;
        st_next[0].rem_h  = REM_W'(s1_mag_reg) * REM_W'(HUE_MUL);
        st_next[0].q_h    = '0;
        st_next[0].rem_s  = REM_W'(s1_d_reg) * REM_W'(SAT_MUL);
        st_next[0].q_s    = '0;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            st_next[k+1] = st_reg[k];
            sh_h = REM_W'(st_reg[k].dh) << (Q_W - 1 - k);
            sh_s = REM_W'(st_reg[k].val) << (Q_W - 1 - k);
            if (st_reg[k].rem_h >= sh_h)
            begin
                st_next[k+1].rem_h            = st_reg[k].rem_h - sh_h;
                st_next[k+1].q_h[Q_W - 1 - k] = 1'b1;
            end
            if (st_reg[k].rem_s >= sh_s)
            begin
                st_next[k+1].rem_s            = st_reg[k].rem_s - sh_s;
                st_next[k+1].q_s[Q_W - 1 - k] = 1'b1;
            end
        end
    end

    // Output stage: sector base hue, ceiling quotient for negative green or blue deltas.
    always_comb
    begin
        logic [HUE_W-1:0] q;
        logic [HUE_W-1:0] rnz;
        q   = HUE_W'(st_reg[DIV_STAGES].q_h);
        rnz = HUE_W'(st_reg[DIV_STAGES].rem_h != '0);
        case (st_reg[DIV_STAGES].sector)
            SECT_RED:
            begin
                if (!st_reg[DIV_STAGES].neg || q == '0)
                begin
                    hue_next = q;
                end
                else
                begin
                    hue_next = HUE_W'(HUE_FULL) - q;
                end
            end
            SECT_GREEN:
            begin
                hue_next = st_reg[DIV_STAGES].neg ? HUE_W'(HUE_GREEN) - q - rnz
                                                  : HUE_W'(HUE_GREEN) + q;
            end
            SECT_BLUE:
            begin
                hue_next = st_reg[DIV_STAGES].neg ? HUE_W'(HUE_BLUE) - q - rnz
                                                  : HUE_W'(HUE_BLUE) + q;
            end
            default:
            begin
                hue_next = '0;
            end
        endcase
        sat_next = st_reg[DIV_STAGES].q_s;
        if (st_reg[DIV_STAGES].flat)
        begin
            hue_next = '0;
            sat_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            v_reg        <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start;
            v_reg        <= {v_reg[DIV_STAGES-1:0], s1_valid_reg};
            done_reg     <= v_reg[DIV_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sector_reg <= s1_sector_next;
        s1_neg_reg    <= s1_neg_next;
        s1_mag_reg    <= s1_mag_next;
        s1_d_reg      <= s1_d_next;
        s1_max_reg    <= s1_max_next;
        s1_sum_reg    <= s1_sum_next;
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        hue_reg  <= hue_next;
        sat_reg  <= sat_next;
        val_reg  <= st_reg[DIV_STAGES].val;
        gray_reg <= st_reg[DIV_STAGES].gray;
    end

    assign done     = done_reg;
    assign hue_deg  = hue_reg;
    assign sat_pct  = sat_reg;
    assign val_max  = val_reg;
    assign gray_avg = gray_reg;

endmodule

// File: rtl/rgbhsv_checker.sv
// Port-level checker for the RGB to HSV pixel converter, bound to the top level.
module rgbhsv_checker
    import rgbhsv_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic [CH_W-1:0]   red_in,
    input logic [CH_W-1:0]   green_in,
    input logic [CH_W-1:0]   blue_in,
    input logic              done,
    input logic [HUE_W-1:0]  hue_deg,
    input logic [SAT_W-1:0]  sat_pct,
    input logic [CH_W-1:0]   val_max,
    input logic [CH_W-1:0]   gray_avg
);

    a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not produce a result at the expected latency");

    a_result_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result appeared without a matching request");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (hue_deg < HUE_W'(HUE_FULL) && sat_pct <= SAT_W'(SAT_FULL)))
        else $error("hue or saturation out of range");

    a_gray_below_max: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (gray_avg <= val_max))
        else $error("grey level exceeds channel maximum");

endmodule

bind rgb_to_hsv_pixel rgbhsv_checker u_rgbhsv_checker (.*);
